// ===== hw/rtl/pts_pkg.sv =====
package pts_pkg;

  localparam int unsigned THREADS = 32;
  localparam int unsigned LEVELS  = 16;
  localparam int unsigned TW      = $clog2(THREADS);
  localparam int unsigned LW      = $clog2(LEVELS);
  localparam int unsigned TIME_W  = 63;
  localparam int unsigned SYS_W   = 64;
  localparam int unsigned CNT_W   = $clog2(THREADS + 1);
  localparam logic [31:0] TICK_NS_RESET = 32'd1000000;

  typedef enum logic [2:0] {
    TS_DELETED  = 3'd0,
    TS_RUNNING  = 3'd1,
    TS_READY    = 3'd2,
    TS_SLEEPING = 3'd3,
    TS_WAITING  = 3'd4,
    TS_STOPPED  = 3'd5
  } thread_state_e;

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_ADMIT  = 3'd1,
    MODE_WAKEUP = 3'd2,
    MODE_SLEEP  = 3'd3,
    MODE_WAIT   = 3'd4,
    MODE_STOP   = 3'd5,
    MODE_RESCHED = 3'd6,
    MODE_UNUSED = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_RSVD    = 2'd3
  } status_e;

  typedef struct packed {
    logic              v;
    logic [TIME_W-1:0] tm;
    logic [TW-1:0]     thr;
  } sleep_entry_t;

  typedef struct packed {
    logic              ins;
    logic              rm;
    logic [TIME_W-1:0] tm;
    logic [TW-1:0]     thr;
  } sleep_cmd_t;

endpackage

// ===== hw/rtl/pts_req_if.sv =====
interface pts_req_if import pts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic [4:0]        target_id;
  logic [3:0]        priority_req;
  logic [TIME_W-1:0] resume_time;
  logic              wake_stopped;

  modport source (output valid, mode, target_id, priority_req, resume_time, wake_stopped,
                  input ready);
  modport sink (input valid, mode, target_id, priority_req, resume_time, wake_stopped,
                output ready);
endinterface

// ===== hw/rtl/pts_rsp_if.sv =====
interface pts_rsp_if import pts_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [4:0] running_thread;
  logic       switched;
  logic [1:0] status;
  logic [5:0] woken_count;

  modport source (output valid, running_thread, switched, status, woken_count,
                  input ready);
  modport sink (input valid, running_thread, switched, status, woken_count,
                output ready);
endinterface

// ===== hw/rtl/pts_sleep_cell.sv =====
module pts_sleep_cell import pts_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  sleep_cmd_t   cmd_i,
  input  sleep_entry_t left_i,
  input  logic         left_lt_i,
  input  sleep_entry_t right_i,
  input  logic         pre_i,
  output sleep_entry_t ent_o,
  output logic         lt_o,
  output logic         pre_o
);

  sleep_entry_t ent_q, ent_d;
  logic         hit;

  assign lt_o  = ent_q.v && (ent_q.tm < cmd_i.tm);
  assign hit   = cmd_i.rm && ent_q.v && (ent_q.thr == cmd_i.thr);
  assign pre_o = pre_i || hit;
  assign ent_o = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (cmd_i.ins) begin
      if (!lt_o) begin
        if (left_lt_i) begin
          ent_d.v   = 1'b1;
          ent_d.tm  = cmd_i.tm;
          ent_d.thr = cmd_i.thr;
        end else begin
          ent_d = left_i;
        end
      end
    end else if (cmd_i.rm && pre_o) begin
      ent_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

endmodule

// ===== hw/rtl/priority_thread_scheduler.sv =====
// Priority thread scheduler.
// req carries one operation per transaction (mode, target_id, priority_req,
// resume_time, wake_stopped); rsp returns exactly one result per request with
// the running thread, a switched flag, a status code and the tick wake count.
// cfg_we_i/cfg_wdata_i write the nanoseconds added per tick; write only idle.
// The block takes one request at a time: req.ready is high only while the
// sequencer is idle. A tick removes each expired sleeper (up to 32) from the
// head of the sleep cell row and pushes it onto its ready list in turn. The
// next request can be accepted in the cycle after the result is registered.
// Ready lists, per-thread state and priority are read through one address
// per cycle, which sets the step count of push, pop and selection.
// The sleep list is a row of 32 cells that shift right on insert and left on
// removal.
// After reset thread 0 runs, all other threads are deleted, time is zero and
// the tick is 1000000 ns. A finished result sits in the rsp register; while
// the receiver stalls the sequencer can still take one further request, but
// it holds in its last step with that result and takes no request after it.
module priority_thread_scheduler import pts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  pts_req_if.sink     req,
  pts_rsp_if.source   rsp
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DEC   = 9'b000000010,
    S_TICK  = 9'b000000100,
    S_TCHK  = 9'b000001000,
    S_PUSHA = 9'b000010000,
    S_PUSHB = 9'b000100000,
    S_SEL   = 9'b001000000,
    S_POP   = 9'b010000000,
    S_FIN   = 9'b100000000
  } seq_e;

  seq_e st_q, st_d;
  logic [31:0]       tick_q;
  logic [SYS_W-1:0]  sys_q, sys_d;
  thread_state_e     tstate_q [THREADS];
  thread_state_e     tstate_d [THREADS];
  logic [LW-1:0]     prio_q [THREADS];
  logic [LW-1:0]     prio_d [THREADS];
  logic [TW-1:0]     link_q [THREADS];
  logic [TW-1:0]     link_d [THREADS];
  logic [TW-1:0]     head_q [LEVELS];
  logic [TW-1:0]     head_d [LEVELS];
  logic [TW-1:0]     tail_q [LEVELS];
  logic [TW-1:0]     tail_d [LEVELS];
  logic [LEVELS-1:0] nonempty_q, nonempty_d;
  logic [TW-1:0]     cur_q, cur_d, before_q, before_d, addr_q, addr_d, tid_q, tid_d;
  logic [LW-1:0]     lvl_q, lvl_d, preq_q, preq_d;
  mode_e             mode_q, mode_d;
  logic [TIME_W-1:0] when_q, when_d;
  logic              ws_q, ws_d, ret_tick_q, ret_tick_d, prev_run_q, prev_run_d;
  status_e           status_q, status_d;
  logic [CNT_W-1:0]  woken_q, woken_d;
  logic              rsp_v_q, rsp_v_d;
  logic [TW-1:0]     out_run_q, out_run_d;
  logic              out_sw_q, out_sw_d;
  status_e           out_st_q, out_st_d;
  logic [5:0]        out_wk_q, out_wk_d;

  sleep_cmd_t        cmd;
  logic              pre0;
  sleep_entry_t      ent [THREADS];
  logic              lt [THREADS];
  logic              pre [THREADS+1];

  thread_state_e     rd_state;
  logic [LW-1:0]     rd_prio;
  logic [LW-1:0]     top_lvl;
  logic              any_ready;
  logic [TW-1:0]     pop_t;

  assign pre[0] = pre0;

  for (genvar i = 0; i < THREADS; i++) begin : g_cell
    sleep_entry_t left_e, right_e;
    logic         left_lt;
    if (i == 0) begin : g_first
      assign left_e  = '0;
      assign left_lt = 1'b1;
    end else begin : g_mid
      assign left_e  = ent[i-1];
      assign left_lt = lt[i-1];
    end
    if (i == THREADS - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_nlast
      assign right_e = ent[i+1];
    end
    pts_sleep_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .left_i    (left_e),
      .left_lt_i (left_lt),
      .right_i   (right_e),
      .pre_i     (pre[i]),
      .ent_o     (ent[i]),
      .lt_o      (lt[i]),
      .pre_o     (pre[i+1])
    );
  end

  assign rd_state = tstate_q[addr_q];
  assign rd_prio  = prio_q[addr_q];
  assign pop_t    = head_q[lvl_q];

  always_comb begin
    top_lvl   = '0;
    any_ready = 1'b0;
    for (int l = 0; l < LEVELS; l++) begin
      if (nonempty_q[l]) begin
        top_lvl   = LW'(l);
        any_ready = 1'b1;
      end
    end
  end

  assign req.ready          = (st_q == S_IDLE);
  assign rsp.valid          = rsp_v_q;
  assign rsp.running_thread = out_run_q;
  assign rsp.switched       = out_sw_q;
  assign rsp.status         = out_st_q;
  assign rsp.woken_count    = out_wk_q;

  always_comb begin
    st_d       = st_q;
    sys_d      = sys_q;
    tstate_d   = tstate_q;
    prio_d     = prio_q;
    link_d     = link_q;
    head_d     = head_q;
    tail_d     = tail_q;
    nonempty_d = nonempty_q;
    cur_d      = cur_q;
    before_d   = before_q;
    addr_d     = addr_q;
    tid_d      = tid_q;
    lvl_d      = lvl_q;
    preq_d     = preq_q;
    mode_d     = mode_q;
    when_d     = when_q;
    ws_d       = ws_q;
    ret_tick_d = ret_tick_q;
    prev_run_d = prev_run_q;
    status_d   = status_q;
    woken_d    = woken_q;
    rsp_v_d    = rsp_v_q && !rsp.ready;
    out_run_d  = out_run_q;
    out_sw_d   = out_sw_q;
    out_st_d   = out_st_q;
    out_wk_d   = out_wk_q;
    cmd        = '0;
    cmd.tm     = when_q;
    cmd.thr    = addr_q;
    pre0       = 1'b0;

    case (st_q)
      S_IDLE: begin
        if (req.valid) begin
          mode_d     = mode_e'(req.mode);
          tid_d      = req.target_id;
          preq_d     = req.priority_req;
          when_d     = req.resume_time;
          ws_d       = req.wake_stopped;
          before_d   = cur_q;
          status_d   = STATUS_OK;
          woken_d    = '0;
          ret_tick_d = 1'b0;
          if (mode_e'(req.mode) == MODE_ADMIT || mode_e'(req.mode) == MODE_WAKEUP) begin
            addr_d = req.target_id;
          end else begin
            addr_d = cur_q;
          end
          if (mode_e'(req.mode) == MODE_TICK) begin
            sys_d = sys_q + {32'd0, tick_q};
          end
          st_d = S_DEC;
        end
      end
      S_DEC: begin
        case (mode_q)
          MODE_TICK: st_d = S_TICK;
          MODE_ADMIT: begin
            if (32'(tid_q) >= THREADS || 32'(preq_q) >= LEVELS || rd_state != TS_DELETED) begin
              status_d = STATUS_INVALID;
              st_d     = S_FIN;
            end else begin
              prio_d[addr_q] = preq_q;
              st_d           = S_PUSHA;
            end
          end
          MODE_WAKEUP: begin
            if (32'(tid_q) >= THREADS) begin
              status_d = STATUS_INVALID;
              st_d     = S_FIN;
            end else if (rd_state == TS_SLEEPING) begin
              cmd.rm = 1'b1;
              st_d   = S_PUSHA;
            end else if (rd_state == TS_WAITING || (ws_q && rd_state == TS_STOPPED)) begin
              st_d = S_PUSHA;
            end else begin
              status_d = STATUS_INVALID;
              st_d     = S_FIN;
            end
          end
          MODE_SLEEP, MODE_WAIT, MODE_STOP: begin
            if (rd_state != TS_RUNNING) begin
              status_d = STATUS_INVALID;
              st_d     = S_FIN;
            end else if (mode_q == MODE_SLEEP && ent[THREADS-1].v) begin
              status_d = STATUS_FULL;
              st_d     = S_FIN;
            end else begin
              if (mode_q == MODE_SLEEP) begin
                cmd.ins          = 1'b1;
                tstate_d[addr_q] = TS_SLEEPING;
              end else if (mode_q == MODE_WAIT) begin
                tstate_d[addr_q] = TS_WAITING;
              end else begin
                tstate_d[addr_q] = TS_STOPPED;
              end
              st_d = S_SEL;
            end
          end
          MODE_RESCHED: st_d = S_SEL;
          default: begin
            status_d = STATUS_INVALID;
            st_d     = S_FIN;
          end
        endcase
      end
      S_TICK: begin
        if (ent[0].v && ({1'b0, ent[0].tm} <= sys_q)) begin
          cmd.rm = 1'b1;
          pre0   = 1'b1;
          addr_d = ent[0].thr;
          st_d   = S_TCHK;
        end else begin
          addr_d = cur_q;
          st_d   = S_SEL;
        end
      end
      S_TCHK: begin
        if (rd_state == TS_SLEEPING) begin
          woken_d    = woken_q + CNT_W'(1);
          ret_tick_d = 1'b1;
          st_d       = S_PUSHA;
        end else begin
          st_d = S_TICK;
        end
      end
      S_PUSHA: begin
        lvl_d            = rd_prio;
        tstate_d[addr_q] = TS_READY;
        st_d             = S_PUSHB;
      end
      S_PUSHB: begin
        if (nonempty_q[lvl_q]) begin
          link_d[tail_q[lvl_q]] = addr_q;
        end else begin
          head_d[lvl_q] = addr_q;
        end
        tail_d[lvl_q]     = addr_q;
        nonempty_d[lvl_q] = 1'b1;
        if (ret_tick_q) begin
          ret_tick_d = 1'b0;
          st_d       = S_TICK;
        end else begin
          st_d = S_FIN;
        end
      end
      S_SEL: begin
        prev_run_d = (rd_state == TS_RUNNING);
        lvl_d      = top_lvl;
        if (any_ready && (rd_state != TS_RUNNING || top_lvl >= rd_prio)) begin
          st_d = S_POP;
        end else begin
          st_d = S_FIN;
        end
      end
      S_POP: begin
        if (head_q[lvl_q] == tail_q[lvl_q]) begin
          nonempty_d[lvl_q] = 1'b0;
        end else begin
          head_d[lvl_q] = link_q[pop_t];
        end
        tstate_d[pop_t] = TS_RUNNING;
        cur_d           = pop_t;
        st_d            = prev_run_q ? S_PUSHA : S_FIN;
      end
      S_FIN: begin
        if (!rsp_v_q || rsp.ready) begin
          rsp_v_d   = 1'b1;
          out_run_d = cur_q;
          out_sw_d  = (cur_q != before_q);
          out_st_d  = status_q;
          out_wk_d  = 6'(woken_q);
          st_d      = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      tick_q     <= TICK_NS_RESET;
      sys_q      <= '0;
      nonempty_q <= '0;
      cur_q      <= '0;
      rsp_v_q    <= 1'b0;
      ret_tick_q <= 1'b0;
      for (int i = 0; i < THREADS; i++) begin
        tstate_q[i] <= (i == 0) ? TS_RUNNING : TS_DELETED;
        prio_q[i]   <= '0;
      end
    end else begin
      st_q       <= st_d;
      sys_q      <= sys_d;
      nonempty_q <= nonempty_d;
      cur_q      <= cur_d;
      rsp_v_q    <= rsp_v_d;
      ret_tick_q <= ret_tick_d;
      tstate_q   <= tstate_d;
      prio_q     <= prio_d;
      if (cfg_we_i) begin
        tick_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    link_q     <= link_d;
    head_q     <= head_d;
    tail_q     <= tail_d;
    before_q   <= before_d;
    addr_q     <= addr_d;
    tid_q      <= tid_d;
    lvl_q      <= lvl_d;
    preq_q     <= preq_d;
    mode_q     <= mode_d;
    when_q     <= when_d;
    ws_q       <= ws_d;
    prev_run_q <= prev_run_d;
    status_q   <= status_d;
    woken_q    <= woken_d;
    out_run_q  <= out_run_d;
    out_sw_q   <= out_sw_d;
    out_st_q   <= out_st_d;
    out_wk_q   <= out_wk_d;
  end

  a_seq_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q)) else $error("sequencer state not one-hot");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_POP) |-> nonempty_q[lvl_q]) else $error("pop from empty level");

  a_sleep_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ent[0].v && ent[1].v) |-> (ent[0].tm <= ent[1].tm)) else $error("sleep head unsorted");

  a_woken_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_v_q |-> (32'(out_wk_q) <= THREADS)) else $error("woken count exceeds threads");

  a_push_resel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_POP && prev_run_q) |=> (st_q == S_PUSHA && addr_q == before_q))
    else $error("preempted thread not requeued");

endmodule

// ===== tb/sv/pts_tb_if.sv =====
`timescale 1ns / 1ps
package pts_tb_pkg;
  import pts_pkg::*;

  typedef struct packed {
    logic [2:0]        mode;
    logic [4:0]        target_id;
    logic [3:0]        priority_req;
    logic [TIME_W-1:0] resume_time;
    logic              wake_stopped;
  } sched_op_t;

  typedef struct packed {
    logic [4:0] running_thread;
    logic       switched;
    logic [1:0] status;
    logic [5:0] woken_count;
  } sched_result_t;
endpackage

// ===== tb/sv/priority_thread_scheduler_tb.sv =====
`timescale 1ns / 1ps
module priority_thread_scheduler_tb;
  import pts_pkg::*;
  import pts_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  pts_req_if req ();
  pts_rsp_if rsp ();

  priority_thread_scheduler uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req(req.sink), .rsp(rsp.source)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // scheduler shadow state
  thread_state_e     th_state [THREADS];
  logic [3:0]        th_prio [THREADS];
  int                lvl_fifo [LEVELS][$];
  logic [TIME_W-1:0] slp_time [$];
  int                slp_thr [$];
  logic [63:0]       sys_ns;
  int                cur_thr;
  logic [31:0]       tick_ns;

  sched_result_t expected_results [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  task automatic shadow_reset();
    for (int i = 0; i < THREADS; i++) begin
      th_state[i] = TS_DELETED;
      th_prio[i] = '0;
    end
    for (int l = 0; l < LEVELS; l++) lvl_fifo[l].delete();
    slp_time.delete();
    slp_thr.delete();
    sys_ns = '0;
    cur_thr = 0;
    th_state[0] = TS_RUNNING;
    tick_ns = TICK_NS_RESET;
  endtask

  function automatic void make_ready(int t);
    th_state[t] = TS_READY;
    lvl_fifo[th_prio[t]].push_back(t);
  endfunction

  function automatic void pick_next();
    int prev;
    bit prev_run;
    int nxt;
    prev = cur_thr;
    prev_run = (th_state[prev] == TS_RUNNING);
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (lvl_fifo[l].size() == 0) continue;
      if (!prev_run || l >= th_prio[prev]) begin
        nxt = lvl_fifo[l].pop_front();
        if (prev_run) make_ready(prev);
        th_state[nxt] = TS_RUNNING;
        cur_thr = nxt;
        return;
      end
    end
  endfunction

  function automatic sched_result_t schedule_op(sched_op_t op);
    sched_result_t r;
    int start_thr;
    int pos;
    int t;
    logic [1:0] st;
    int woken;
    start_thr = cur_thr;
    st = STATUS_OK;
    woken = 0;
    case (mode_e'(op.mode))
      MODE_TICK: begin
        sys_ns = sys_ns + 64'(tick_ns);
        while (slp_time.size() > 0 && 64'(slp_time[0]) <= sys_ns) begin
          t = slp_thr.pop_front();
          void'(slp_time.pop_front());
          if (th_state[t] == TS_SLEEPING) begin
            make_ready(t);
            woken++;
          end
        end
        pick_next();
      end
      MODE_ADMIT: begin
        if (th_state[op.target_id] != TS_DELETED) st = STATUS_INVALID;
        else begin
          th_prio[op.target_id] = op.priority_req;
          make_ready(op.target_id);
        end
      end
      MODE_WAKEUP: begin
        t = op.target_id;
        if (th_state[t] == TS_SLEEPING) begin
          for (int i = slp_thr.size() - 1; i >= 0; i--) begin
            if (slp_thr[i] == t) begin
              slp_thr.delete(i);
              slp_time.delete(i);
            end
          end
          make_ready(t);
        end else if (th_state[t] == TS_WAITING ||
                     (op.wake_stopped && th_state[t] == TS_STOPPED)) begin
          make_ready(t);
        end else st = STATUS_INVALID;
      end
      MODE_SLEEP, MODE_WAIT, MODE_STOP: begin
        if (th_state[cur_thr] != TS_RUNNING) st = STATUS_INVALID;
        else if (op.mode == MODE_SLEEP && slp_thr.size() >= THREADS) st = STATUS_FULL;
        else begin
          if (op.mode == MODE_SLEEP) begin
            pos = 0;
            while (pos < slp_time.size() && slp_time[pos] < op.resume_time) pos++;
            slp_time.insert(pos, op.resume_time);
            slp_thr.insert(pos, cur_thr);
            th_state[cur_thr] = TS_SLEEPING;
          end else if (op.mode == MODE_WAIT) th_state[cur_thr] = TS_WAITING;
          else th_state[cur_thr] = TS_STOPPED;
          pick_next();
        end
      end
      MODE_RESCHED: pick_next();
      default: st = STATUS_INVALID;
    endcase
    r.running_thread = 5'(cur_thr);
    r.switched = (cur_thr != start_thr);
    r.status = st;
    r.woken_count = 6'(woken);
    return r;
  endfunction

  // one transaction on the request channel; valid stays up until the next
  // idle cycle or drain
  task automatic send_op(sched_op_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.mode <= op.mode;
    req.target_id <= op.target_id;
    req.priority_req <= op.priority_req;
    req.resume_time <= op.resume_time;
    req.wake_stopped <= op.wake_stopped;
    do @(posedge clk_i); while (!req.ready);
    expected_results.push_back(schedule_op(op));
  endtask

  function automatic sched_op_t mk_op(mode_e m, int tid = 0, int pr = 0,
                                      logic [TIME_W-1:0] rt = '0, bit ws = 1'b0);
    sched_op_t op;
    op.mode = m;
    op.target_id = 5'(tid);
    op.priority_req = 4'(pr);
    op.resume_time = rt;
    op.wake_stopped = ws;
    return op;
  endfunction

  task automatic drain();
    req.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_tick(logic [31:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tick_ns = v;
  endtask

  // receiver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", {rsp.running_thread,
            rsp.switched, rsp.status, rsp.woken_count});
        end else begin
          sched_result_t e;
          e = expected_results.pop_front();
          if (e.running_thread !== rsp.running_thread || e.switched !== rsp.switched ||
              e.status !== rsp.status || e.woken_count !== rsp.woken_count) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp thr=%0d sw=%0d st=%0d wk=%0d got thr=%0d sw=%0d st=%0d wk=%0d",
                e.running_thread, e.switched, e.status, e.woken_count,
                rsp.running_thread, rsp.switched, rsp.status, rsp.woken_count);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        rsp.ready <= 1'b0;
      end else rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_directed();
    send_op(mk_op(MODE_RESCHED));
    send_op(mk_op(MODE_UNUSED));
    send_op(mk_op(MODE_ADMIT, 0, 3));
    send_op(mk_op(MODE_ADMIT, 31, 15));
    send_op(mk_op(MODE_ADMIT, 1, 0));
    send_op(mk_op(MODE_ADMIT, 2, 15));
    send_op(mk_op(MODE_RESCHED));
    send_op(mk_op(MODE_SLEEP, 0, 0, '1));
    send_op(mk_op(MODE_SLEEP, 0, 0, '0));
    send_op(mk_op(MODE_TICK));
    send_op(mk_op(MODE_WAIT));
    send_op(mk_op(MODE_STOP));
    send_op(mk_op(MODE_WAKEUP, 31, 0, '0, 1'b0));
    send_op(mk_op(MODE_WAKEUP, 31, 0, '0, 1'b1));
    send_op(mk_op(MODE_WAKEUP, 2));
    send_op(mk_op(MODE_WAKEUP, 5));
    send_op(mk_op(MODE_STOP));
    send_op(mk_op(MODE_STOP));
    send_op(mk_op(MODE_STOP));
    send_op(mk_op(MODE_STOP));
    send_op(mk_op(MODE_SLEEP));
    send_op(mk_op(MODE_TICK));
    send_op(mk_op(MODE_WAKEUP, 31, 0, '0, 1'b1));
  endtask

  // fills the sleep list to its limit and beyond
  task automatic test_full_list();
    for (int i = 3; i < THREADS; i++) send_op(mk_op(MODE_ADMIT, i, $urandom_range(15)));
    for (int i = 0; i < THREADS + 3; i++) begin
      if (th_state[cur_thr] != TS_RUNNING) send_op(mk_op(MODE_RESCHED));
      send_op(mk_op(MODE_SLEEP, 0, 0, 63'($urandom_range(5)) * 63'd1000));
    end
    write_tick(32'hFFFF_FFFF);
    send_op(mk_op(MODE_TICK));
  endtask

  task automatic test_random(int n);
    sched_op_t op;
    for (int i = 0; i < n; i++) begin
      op.mode = 3'($urandom_range(6));
      if ($urandom_range(49) == 0) op.mode = MODE_UNUSED;
      op.target_id = 5'($urandom);
      op.priority_req = 4'($urandom);
      op.wake_stopped = 1'($urandom);
      case ($urandom_range(3))
        0: op.resume_time = {31'($urandom), 32'($urandom)};
        1: op.resume_time = 63'(sys_ns) + 63'($urandom_range(8)) * 63'(tick_ns);
        default: op.resume_time = 63'(sys_ns) + 63'($urandom_range(3000000));
      endcase
      if (op.mode == MODE_WAIT && $urandom_range(1)) op.mode = MODE_TICK;
      send_op(op);
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 10; i++) send_op(mk_op(MODE_RESCHED));
  endtask

  initial begin
    req.valid = 1'b0;
    req.mode = '0;
    req.target_id = '0;
    req.priority_req = '0;
    req.resume_time = '0;
    req.wake_stopped = 1'b0;
    rsp.ready = 1'b0;
    shadow_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 9;
    recv_idle_pct = 68;
    test_directed();
    test_full_list();
    write_tick(32'd1);
    test_random(130);
    test_backpressure();
    send_idle_pct = 68;
    recv_idle_pct = 9;
    write_tick(32'd1000000);
    test_random(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_tick(32'd777);
    test_random(90);
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== priority_thread_scheduler.f =====
hw/rtl/pts_pkg.sv
hw/rtl/pts_req_if.sv
hw/rtl/pts_rsp_if.sv
hw/rtl/pts_sleep_cell.sv
hw/rtl/priority_thread_scheduler.sv
tb/sv/pts_tb_if.sv
tb/sv/priority_thread_scheduler_tb.sv
